// ===== rtl/dtq_pkg.sv =====
// ---------------------------------------------------------------------------
// Deadline timer queue package
// Shared constants, entry and cell control types, command codes and sequencer states.
// ---------------------------------------------------------------------------
package dtq_pkg;

  // Number of cells in the sorted timer chain.
  localparam int QUEUE_DEPTH = 16;
  // Width of the pending count, wide enough to hold QUEUE_DEPTH itself.
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int TIME_W = 64;
  localparam int ID_W   = 32;

  // One timer held in a cell.
  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] deadline;
    logic [ID_W-1:0]   id;
  } dtq_entry_t;

  // Operation applied to all cells of the chain together.
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_CANCEL = 2'd2,
    CELL_POP    = 2'd3
  } cell_op_t;

  // Control word broadcast to every cell. For a cancel, key_id is the id sought.
  typedef struct packed {
    cell_op_t          op;
    logic [TIME_W-1:0] key_dl;
    logic [ID_W-1:0]   key_id;
  } dtq_cell_ctrl_t;

  // Command codes of the input word.
  typedef enum logic [1:0] {
    KIND_SCHEDULE = 2'd0,
    KIND_CANCEL   = 2'd1,
    KIND_ADV_TO   = 2'd2,
    KIND_ADV_BY   = 2'd3
  } kind_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DECODE = 4'b0010,
    ST_APPLY  = 4'b0100,
    ST_POP    = 4'b1000
  } state_t;

endpackage

// ===== rtl/dtq_cell.sv =====
// ---------------------------------------------------------------------------
// Deadline timer queue cell
// One slot of the sorted timer chain. It inserts, removes or shifts its timer
// using only its own contents, its neighbours, the control word and a one-bit chain signal.
// ---------------------------------------------------------------------------
module dtq_cell
  import dtq_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  dtq_cell_ctrl_t ctrl,
  input  dtq_entry_t     left_entry,
  input  dtq_entry_t     right_entry,
  input  logic           chain_in,
  output logic           chain_out,
  output dtq_entry_t     entry
);

  logic              valid_r, valid_nxt;
  logic [TIME_W-1:0] dl_r, dl_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic              key_lt;
  logic              match;

  // Ordering by deadline first and id second, and the id match for a cancel.
  assign key_lt = {ctrl.key_dl, ctrl.key_id} < {dl_r, id_r};
  assign match  = valid_r && (id_r == ctrl.key_id);

  // Chain signal: for an insert it marks cells at or after the new position;
  // for a cancel it marks cells at or after the first matching timer.
  always_comb begin
    case (ctrl.op)
      CELL_INSERT: chain_out = !valid_r || key_lt;
      CELL_CANCEL: chain_out = chain_in || match;
      default:     chain_out = 1'b0;
    endcase
  end

  // Next contents of the cell.
  always_comb begin
    valid_nxt = valid_r;
    dl_nxt    = dl_r;
    id_nxt    = id_r;
    case (ctrl.op)
      CELL_INSERT: begin
        if (chain_out && chain_in) begin
          valid_nxt = left_entry.valid;
          dl_nxt    = left_entry.deadline;
          id_nxt    = left_entry.id;
        end else if (chain_out) begin
          valid_nxt = 1'b1;
          dl_nxt    = ctrl.key_dl;
          id_nxt    = ctrl.key_id;
        end
      end
      CELL_CANCEL: begin
        if (chain_out) begin
          valid_nxt = right_entry.valid;
          dl_nxt    = right_entry.deadline;
          id_nxt    = right_entry.id;
        end
      end
      CELL_POP: begin
        valid_nxt = right_entry.valid;
        dl_nxt    = right_entry.deadline;
        id_nxt    = right_entry.id;
      end
      default: begin
        valid_nxt = valid_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dl_r <= dl_nxt;
    id_r <= id_nxt;
  end

  assign entry = '{valid: valid_r, deadline: dl_r, id: id_r};

endmodule

// ===== rtl/deadline_timer_queue_top.sv =====
// ---------------------------------------------------------------------------
// Deadline timer queue
// Timer queue with a 64-bit current time, scheduling, cancelling and advancing.
// ---------------------------------------------------------------------------
// Use: a command word is taken when start is high and busy is low. It carries
// a kind (schedule, cancel, advance to, advance by) and its operands. Every
// result word appears for one cycle on the out_ ports with out_valid high;
// the receiver cannot stall it. The last word of a command has out_last set.
// Timing: a schedule, a cancel or a rejected advance gives a single word; an
// accepted advance gives one word per cycle, one for each timer that falls
// due and a final status word. busy stays high until the final word is on the
// ports, and the next command may follow in that same cycle. The sequencer
// forms the sum and checks in its decode state, applies the command in its
// apply state, and for an advance pops one timer off the head of the chain
// in each step of its pop state, then gives the final status word.
// Timers live in a sorted chain of QUEUE_DEPTH cells, earliest at cell 0.
// cfg_we loads cfg_wdata into the current time, but not in the pop state. Reset
// clears the time, id counter and all cells; ready in the first cycle after reset.
// ---------------------------------------------------------------------------
module deadline_timer_queue_top
  import dtq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  // Configuration port
  input  logic                     cfg_we,
  input  logic [TIME_W-1:0]        cfg_wdata,
  // Command channel
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_kind,
  input  logic                     in_requester_valid,
  input  logic signed [TIME_W-1:0] in_signed_amount,
  input  logic [TIME_W-1:0]        in_target_time,
  input  logic [ID_W-1:0]          in_cancel_id,
  // Result channel
  output logic                     out_valid,
  output logic                     out_fired,
  output logic [ID_W-1:0]          out_task_id,
  output logic [TIME_W-1:0]        out_fire_time,
  output logic                     out_ok,
  output logic [CNT_W-1:0]         out_pending,
  output logic                     out_last
);

  state_t            state_r, state_nxt;
  kind_t             kind_r;
  logic              req_r;
  logic [TIME_W-1:0] amt_r;
  logic [TIME_W-1:0] target_r;
  logic [ID_W-1:0]   cid_r;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [ID_W-1:0]   id_ctr_r, id_ctr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [TIME_W-1:0] tgt_r;
  logic              rej_r;
  logic [ID_W-1:0]   new_id_r;

  logic              ov_r, ov_nxt;
  logic              of_r, of_nxt;
  logic [ID_W-1:0]   oid_r, oid_nxt;
  logic [TIME_W-1:0] otime_r, otime_nxt;
  logic              ook_r, ook_nxt;
  logic [CNT_W-1:0]  opend_r, opend_nxt;
  logic              olast_r, olast_nxt;

  logic              accept;
  logic [TIME_W-1:0] addend;
  logic [TIME_W:0]   sum;
  logic [ID_W-1:0]   id_inc;
  logic [ID_W-1:0]   new_id;
  logic              rej;
  logic              full;
  logic              removed;
  logic              head_due;

  dtq_cell_ctrl_t    ctrl;
  dtq_entry_t        entries [QUEUE_DEPTH];
  logic              chain   [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_valid;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign full   = (count_r == CNT_W'(QUEUE_DEPTH));

  // Command word capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r   <= kind_t'(in_kind);
      req_r    <= in_requester_valid;
      amt_r    <= $unsigned(in_signed_amount);
      target_r <= in_target_time;
      cid_r    <= in_cancel_id;
    end
  end

  // Sum of the current time and the delay or duration, with overflow; the
  // delay of a schedule is clamped to zero when negative.
  always_comb begin
    if (kind_r == KIND_ADV_BY || !amt_r[TIME_W-1]) begin
      addend = amt_r;
    end else begin
      addend = '0;
    end
    sum    = {1'b0, now_r} + {1'b0, addend};
    id_inc = id_ctr_r + ID_W'(1);
    new_id = (id_inc == '0) ? ID_W'(1) : id_inc;
  end

  // Rejection checks for each kind of command.
  always_comb begin
    case (kind_r)
      KIND_SCHEDULE: rej = !req_r || sum[TIME_W] || full;
      KIND_ADV_TO:   rej = target_r < now_r;
      KIND_ADV_BY:   rej = amt_r[TIME_W-1] || sum[TIME_W];
      default:       rej = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DECODE) begin
      tgt_r    <= (kind_r == KIND_ADV_TO) ? target_r : sum[TIME_W-1:0];
      rej_r    <= rej;
      new_id_r <= new_id;
    end
  end

  // The head cell falls due when it holds a timer no later than the target.
  assign head_due = entries[0].valid && (entries[0].deadline <= tgt_r);

  // Sequencer: drives the chain and forms each result word.
  always_comb begin
    state_nxt  = state_r;
    now_nxt    = now_r;
    id_ctr_nxt = id_ctr_r;
    count_nxt  = count_r;
    ctrl       = '{op: CELL_HOLD, key_dl: tgt_r, key_id: new_id_r};
    ov_nxt     = 1'b0;
    of_nxt     = 1'b0;
    oid_nxt    = '0;
    otime_nxt  = now_r;
    ook_nxt    = 1'b0;
    opend_nxt  = count_r;
    olast_nxt  = 1'b1;
    if (cfg_we) begin
      now_nxt = cfg_wdata;
    end
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        state_nxt = ST_IDLE;
        ov_nxt    = 1'b1;
        case (kind_r)
          KIND_SCHEDULE: begin
            if (!rej_r) begin
              ctrl.op    = CELL_INSERT;
              id_ctr_nxt = new_id_r;
              count_nxt  = count_r + CNT_W'(1);
              oid_nxt    = new_id_r;
              ook_nxt    = 1'b1;
              opend_nxt  = count_r + CNT_W'(1);
            end
          end
          KIND_CANCEL: begin
            if (cid_r != '0) begin
              ctrl.op     = CELL_CANCEL;
              ctrl.key_id = cid_r;
            end
            ook_nxt   = removed;
            count_nxt = count_r - CNT_W'(removed);
            opend_nxt = count_r - CNT_W'(removed);
          end
          default: begin
            // Advance: a rejected command reports at once, otherwise expire.
            if (!rej_r) begin
              state_nxt = ST_POP;
              ov_nxt    = 1'b0;
            end
          end
        endcase
      end
      ST_POP: begin
        ov_nxt = 1'b1;
        if (head_due) begin
          ctrl.op   = CELL_POP;
          now_nxt   = entries[0].deadline;
          count_nxt = count_r - CNT_W'(1);
          of_nxt    = 1'b1;
          oid_nxt   = entries[0].id;
          otime_nxt = entries[0].deadline;
          ook_nxt   = 1'b1;
          opend_nxt = count_r - CNT_W'(1);
          olast_nxt = 1'b0;
        end else begin
          state_nxt = ST_IDLE;
          now_nxt   = tgt_r;
          otime_nxt = tgt_r;
          ook_nxt   = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      now_r    <= '0;
      id_ctr_r <= '0;
      count_r  <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      now_r    <= now_nxt;
      id_ctr_r <= id_ctr_nxt;
      count_r  <= count_nxt;
      ov_r     <= ov_nxt;
    end
  end

  // Result word register.
  always_ff @(posedge clk) begin
    of_r    <= of_nxt;
    oid_r   <= oid_nxt;
    otime_r <= otime_nxt;
    ook_r   <= ook_nxt;
    opend_r <= opend_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid     = ov_r;
  assign out_fired     = of_r;
  assign out_task_id   = oid_r;
  assign out_fire_time = otime_r;
  assign out_ok        = ook_r;
  assign out_pending   = opend_r;
  assign out_last      = olast_r;

  // Sorted chain of timer cells, earliest at cell 0.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    dtq_entry_t left_e;
    dtq_entry_t right_e;
    logic       chain_l;

    if (i == 0) begin : g_first
      assign left_e  = '0;
      assign chain_l = 1'b0;
    end else begin : g_mid
      assign left_e  = entries[i-1];
      assign chain_l = chain[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = entries[i+1];
    end

    dtq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .left_entry (left_e),
      .right_entry(right_e),
      .chain_in   (chain_l),
      .chain_out  (chain[i]),
      .entry      (entries[i])
    );

    assign cell_valid[i] = entries[i].valid;
  end

  // A cancel removed a timer when the chain signal reached the last cell.
  assign removed = chain[QUEUE_DEPTH-1];

  // The pending count always agrees with the occupied cells.
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == CNT_W'($countones(cell_valid)))
    else $error("pending count differs from occupied cells");

  // Occupied cells stay packed at the head of the chain.
  a_cells_packed: assert property (@(posedge clk) disable iff (!rst_n)
    ((cell_valid + QUEUE_DEPTH'(1)) & cell_valid) == '0)
    else $error("occupied cells are not contiguous from the head");

  // A result word only follows an apply or pop step of the sequencer.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == ST_APPLY || $past(state_r) == ST_POP))
    else $error("result word without a sequencer step");

  // An expired timer is never the last word of a command.
  a_fired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_fired) |=> (busy || out_valid))
    else $error("advance ended on an expired timer word");

endmodule
